/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NGH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ngh assertion failed");

// next-cycle implication
`define NGH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ngh assertion failed");

`endif

/* sv/ngh_pkg.sv */
`timescale 1ns / 1ps
package ngh_pkg;

    localparam int KIND_W      = 2;
    localparam int IN_TDATA_W  = 240;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 31;
    localparam int ROW_W       = 31;
    localparam int CODE_W      = 32;
    localparam int VAL_W       = 64;
    localparam int DIV_W       = 63;
    localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

    // input tdata field positions
    localparam int IN_LAYER   = 0;
    localparam int IN_IDX_LO  = 1;
    localparam int IN_VAL_LO  = 6;
    localparam int IN_OFF_LO  = 70;
    localparam int IN_OWNED   = 101;
    localparam int IN_TOK_LO  = 102;
    localparam int IN_HLEN_LO = 134;
    localparam int IN_H0_LO   = 136;
    localparam int IN_H1_LO   = 168;
    localparam int IN_H2_LO   = 200;
    localparam int IN_LATE    = 232;

    // pipeline stage map
    localparam int DIV_STEPS = 64;
    localparam int ST_ISS    = 0;
    localparam int ST_MAG    = 1;
    localparam int ST_DIV0   = 2;
    localparam int ST_FIX    = ST_DIV0 + DIV_STEPS;
    localparam int ST_ADD    = ST_FIX + 1;
    localparam int ST_CHK    = ST_ADD + 1;
    localparam int NST       = ST_CHK + 1;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD_HEAD = 2'd0,
        K_LOAD_MULT = 2'd1,
        K_HASH      = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_OVF = 2'd1,
        STAT_OUT = 2'd2,
        STAT_REJ = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAD    = 3'd0,
        CFG_START0 = 3'd1,
        CFG_STOP0  = 3'd2,
        CFG_START1 = 3'd3,
        CFG_STOP1  = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MLO   = 5'b00010,
        S_MHI   = 5'b00100,
        S_FOLD  = 5'b01000,
        S_ISSUE = 5'b10000
    } t_state;

    typedef struct packed {
        logic              reject;
        logic              last;
        logic              checked;
        logic              owned;
        logic [1:0]        layer;
        logic [5:0]        head;
        logic [3:0]        ridx;
        logic              neg;
        logic              ovf;
        logic [DIV_W-1:0]  dsr;
        logic [VAL_W-1:0]  mag;
        logic [VAL_W-1:0]  rem;
        logic [ROW_W-1:0]  off;
        logic [ROW_W-1:0]  row;
        t_status           status;
    } t_item;

endpackage

/* sv/ngh_ram.sv */
`timescale 1ns / 1ps
module ngh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/ngram_head_row_hash.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// N-gram head row hasher. A rejected head load emits one result through
// the same result path. A hash request holds the input through rolling-hash
// folding (one 31x32 multiply per cycle, two per 64-bit product, then a
// fold), then through issuing heads, one per cycle, into a 69-stage modulo
// pipeline (a 64-step restoring divider sets its depth). Issue pauses in
// any cycle in which the result register holds a result that is not taken.
// The next request is taken only after the last head has issued. Results
// leave at one per cycle while the output is not stalled.
module ngram_head_row_hash #(
    parameter int LAYER_COUNT     = 2,
    parameter int HEADS_PER_ORDER = 8,
    parameter int MAX_HISTORY     = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // layer_sel, entry_index, table_value, row_offset, head_owned, token_code,
    // history_len, hist_newest, hist_middle, hist_oldest, late flag
    input  logic [ngh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind
    input  logic [ngh_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_layer, out_head, row_index, out_owned, status, request_failed
    output logic [ngh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [ngh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ngh_pkg::CFG_W-1:0]          i_cfg_data
);
    import ngh_pkg::*;

    localparam int HPL        = MAX_HISTORY * HEADS_PER_ORDER;
    localparam int HEAD_DEPTH = LAYER_COUNT * HPL;
    localparam int MULT_DEPTH = LAYER_COUNT * (MAX_HISTORY + 1);
    localparam int ROLL_DEPTH = LAYER_COUNT * MAX_HISTORY;
    localparam int HA_W = HEAD_DEPTH > 1 ? $clog2(HEAD_DEPTH) : 1;
    localparam int MA_W = MULT_DEPTH > 1 ? $clog2(MULT_DEPTH) : 1;
    localparam int RA_W = ROLL_DEPTH > 1 ? $clog2(ROLL_DEPTH) : 1;
    localparam int LW   = LAYER_COUNT > 1 ? $clog2(LAYER_COUNT) : 1;
    localparam int SW   = $clog2(MAX_HISTORY + 1);
    localparam int HW   = HPL > 1 ? $clog2(HPL) : 1;
    localparam int KW   = HEADS_PER_ORDER > 1 ? $clog2(HEADS_PER_ORDER) : 1;

    // configuration
    logic [ROW_W-1:0] r_pad, r_start0, r_stop0, r_start1, r_stop1;

    // tables
    logic [VAL_W-1:0]      r_mult [MULT_DEPTH];
    logic [HEAD_DEPTH-1:0] r_owned;
    logic [VAL_W-1:0]      r_roll [ROLL_DEPTH];

    // request
    t_state            r_state;
    logic [CODE_W-1:0] r_tok;
    logic [CODE_W-1:0] r_hist [3];
    logic [1:0]        r_hlen;
    logic              r_late;
    logic [LW-1:0]     r_l;
    logic [SW-1:0]     r_s;
    logic [HW-1:0]     r_h;
    logic [KW-1:0]     r_hk;
    logic [RA_W-1:0]   r_ridx;
    logic [62:0]       r_plo, r_phi;
    logic [VAL_W-1:0]  r_acc;

    // pipeline
    logic [NST-1:0] r_v;
    t_item          r_it [NST];
    t_item          n_it [NST];
    logic           n_v0;

    // result register
    logic             r_ovalid, r_olast, r_ofail, r_oowned, r_fail;
    logic [1:0]       r_olayer;
    logic [5:0]       r_ohead;
    logic [ROW_W-1:0] r_orow;
    t_status          r_ostat;

    logic                 w_en, w_acc, w_lh_ok, w_bad_div, w_rej, w_ram_we, w_issue;
    logic [VAL_W-1:0]     w_tval;
    logic [LW-1:0]        w_lsel;
    logic [4:0]           w_eidx;
    logic [ROW_W-1:0]     w_code [MAX_HISTORY+1];
    logic [VAL_W-1:0]     w_prod, w_fold;
    logic [HA_W-1:0]      w_waddr, w_raddr;
    logic [DIV_W+ROW_W-1:0] w_rdata;
    logic                 w_fail;

    assign w_en   = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_en;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_tval = s_axis_tdata[IN_VAL_LO +: VAL_W];
    assign w_lsel = LW'(s_axis_tdata[IN_LAYER]);
    assign w_eidx = s_axis_tdata[IN_IDX_LO +: 5];
    assign w_lh_ok = (int'(s_axis_tdata[IN_LAYER]) < LAYER_COUNT) && (int'(w_eidx) < HPL);
    assign w_bad_div = (w_tval == '0) || w_tval[VAL_W-1];
    assign w_rej    = w_acc && (s_axis_tuser == K_LOAD_HEAD) && w_lh_ok && w_bad_div;
    assign w_ram_we = w_acc && (s_axis_tuser == K_LOAD_HEAD) && w_lh_ok && !w_bad_div;
    assign w_waddr  = HA_W'(int'(s_axis_tdata[IN_LAYER]) * HPL + int'(w_eidx));
    assign w_issue  = (r_state == S_ISSUE) && w_en;
    assign w_raddr  = HA_W'(int'(r_l) * HPL + int'(r_h));

    ngh_ram #(
        .WIDTH (DIV_W + ROW_W),
        .DEPTH (HEAD_DEPTH)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_tval[DIV_W-1:0], s_axis_tdata[IN_OFF_LO +: ROW_W]}),
        .i_re    (w_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // history codes with blocking carried toward older positions
    always_comb begin
        logic             blk;
        logic [CODE_W-1:0] raw;
        blk = 1'b0;
        for (int s = 0; s <= MAX_HISTORY; s++) begin
            raw = '0;
            if (s == 0) begin
                raw = r_tok;
            end else if (s > int'(r_hlen)) begin
                blk = 1'b1;
            end else begin
                raw = r_hist[s-1];
            end
            if (raw[CODE_W-1]) begin
                blk = 1'b1;
            end
            w_code[s] = blk ? r_pad : raw[ROW_W-1:0];
        end
    end

    assign w_prod = {1'b0, r_plo} + {r_phi[31:0], 32'd0};
    assign w_fold = ((r_s == '0) ? '0 : r_acc) ^ w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad    <= '0;
            r_start0 <= '0;
            r_stop0  <= '0;
            r_start1 <= '0;
            r_stop1  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAD:    r_pad    <= i_cfg_data;
                CFG_START0: r_start0 <= i_cfg_data;
                CFG_STOP0:  r_stop0  <= i_cfg_data;
                CFG_START1: r_start1 <= i_cfg_data;
                CFG_STOP1:  r_stop1  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (s_axis_tuser == K_LOAD_MULT)
                && (int'(s_axis_tdata[IN_LAYER]) < LAYER_COUNT)
                && (int'(w_eidx) <= MAX_HISTORY)) begin
            r_mult[MA_W'(int'(w_lsel) * (MAX_HISTORY + 1) + int'(w_eidx))] <= w_tval;
        end
        if (w_acc && (s_axis_tuser == K_HASH)) begin
            r_tok     <= s_axis_tdata[IN_TOK_LO +: CODE_W];
            r_hist[0] <= s_axis_tdata[IN_H0_LO +: CODE_W];
            r_hist[1] <= s_axis_tdata[IN_H1_LO +: CODE_W];
            r_hist[2] <= s_axis_tdata[IN_H2_LO +: CODE_W];
            r_hlen    <= s_axis_tdata[IN_HLEN_LO +: 2];
            r_late    <= s_axis_tdata[IN_LATE];
        end
        if (r_state == S_MLO) begin
            r_plo <= w_code[r_s] * r_mult[MA_W'(int'(r_l) * (MAX_HISTORY + 1) + int'(r_s))][31:0];
        end
        if (r_state == S_MHI) begin
            r_phi <= w_code[r_s] * r_mult[MA_W'(int'(r_l) * (MAX_HISTORY + 1) + int'(r_s))][63:32];
        end
        if (r_state == S_FOLD) begin
            r_acc <= w_fold;
            if (r_s != '0) begin
                r_roll[RA_W'(int'(r_l) * MAX_HISTORY + int'(r_s) - 1)] <= w_fold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owned <= '0;
        end else if (w_ram_we) begin
            r_owned[w_waddr] <= s_axis_tdata[IN_OWNED];
        end
    end

    // request sequencer: fold products, then issue heads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_l     <= '0;
            r_s     <= '0;
            r_h     <= '0;
            r_hk    <= '0;
            r_ridx  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && (s_axis_tuser == K_HASH)) begin
                        r_state <= S_MLO;
                        r_l     <= '0;
                        r_s     <= '0;
                    end
                end
                S_MLO: r_state <= S_MHI;
                S_MHI: r_state <= S_FOLD;
                S_FOLD: begin
                    r_state <= S_MLO;
                    if (r_s == SW'(MAX_HISTORY)) begin
                        r_s <= '0;
                        if (r_l == LW'(LAYER_COUNT - 1)) begin
                            r_state <= S_ISSUE;
                            r_l     <= '0;
                            r_h     <= '0;
                            r_hk    <= '0;
                            r_ridx  <= '0;
                        end else begin
                            r_l <= r_l + 1'b1;
                        end
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                S_ISSUE: begin
                    if (w_en) begin
                        if (r_hk == KW'(HEADS_PER_ORDER - 1)) begin
                            r_hk   <= '0;
                            r_ridx <= r_ridx + 1'b1;
                        end else begin
                            r_hk <= r_hk + 1'b1;
                        end
                        if (r_h == HW'(HPL - 1)) begin
                            r_h <= '0;
                            if (r_l == LW'(LAYER_COUNT - 1)) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_l <= r_l + 1'b1;
                            end
                        end else begin
                            r_h <= r_h + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stage logic
    always_comb begin
        t_item            a;
        logic [VAL_W-1:0] t, rl;
        n_v0 = w_issue || w_rej;
        n_it[ST_ISS] = '0;
        if (w_rej) begin
            n_it[ST_ISS].reject = 1'b1;
            n_it[ST_ISS].last   = 1'b1;
            n_it[ST_ISS].layer  = 2'(s_axis_tdata[IN_LAYER]);
            n_it[ST_ISS].head   = 6'(w_eidx);
        end else begin
            n_it[ST_ISS].last    = (r_l == LW'(LAYER_COUNT - 1)) && (r_h == HW'(HPL - 1));
            n_it[ST_ISS].checked = (int'(r_l) < 2) && !((r_l == '0) && r_late);
            n_it[ST_ISS].owned   = r_owned[w_raddr];
            n_it[ST_ISS].layer   = 2'(r_l);
            n_it[ST_ISS].head    = 6'(r_h);
            n_it[ST_ISS].ridx    = 4'(r_ridx);
        end

        a     = r_it[ST_ISS];
        rl    = r_roll[a.ridx[RA_W-1:0]];
        a.dsr = w_rdata[DIV_W+ROW_W-1:ROW_W];
        a.off = w_rdata[ROW_W-1:0];
        a.neg = rl[VAL_W-1];
        a.mag = rl[VAL_W-1] ? (~rl + 1'b1) : rl;
        a.rem = '0;
        n_it[ST_MAG] = a;

        for (int k = 0; k < DIV_STEPS; k++) begin
            a = r_it[ST_MAG + k];
            t = {a.rem[VAL_W-2:0], a.mag[VAL_W-1-k]};
            if (t >= {1'b0, a.dsr}) begin
                t = t - {1'b0, a.dsr};
            end
            a.rem = t;
            n_it[ST_DIV0 + k] = a;
        end

        a = r_it[ST_FIX - 1];
        if (a.dsr == '0) begin
            a.rem = '0;
        end else if (a.neg && (a.rem != '0)) begin
            a.rem = {1'b0, a.dsr} - a.rem;
        end
        n_it[ST_FIX] = a;

        a     = r_it[ST_FIX];
        t     = a.rem + {33'd0, a.off};
        a.ovf = t > {33'd0, ROW_MAX};
        a.row = a.ovf ? ROW_MAX : t[ROW_W-1:0];
        n_it[ST_ADD] = a;

        a = r_it[ST_ADD];
        if (a.reject) begin
            a.status = STAT_REJ;
            a.row    = '0;
            a.owned  = 1'b0;
        end else if (a.ovf) begin
            a.status = STAT_OVF;
        end else if (a.checked && a.owned
                && !((a.row >= (a.layer[0] ? r_start1 : r_start0))
                  && (a.row < (a.layer[0] ? r_stop1 : r_stop0)))) begin
            a.status = STAT_OUT;
        end else begin
            a.status = STAT_OK;
        end
        n_it[ST_CHK] = a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], n_v0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NST; i++) begin
                r_it[i] <= n_it[i];
            end
        end
    end

    assign w_fail = r_fail || (r_it[ST_CHK].status != STAT_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_fail   <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= r_v[ST_CHK];
            if (r_v[ST_CHK]) begin
                r_fail <= r_it[ST_CHK].last ? 1'b0 : w_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_olayer <= r_it[ST_CHK].layer;
            r_ohead  <= r_it[ST_CHK].head;
            r_orow   <= r_it[ST_CHK].row;
            r_oowned <= r_it[ST_CHK].owned;
            r_ostat  <= r_it[ST_CHK].status;
            r_olast  <= r_it[ST_CHK].last;
            r_ofail  <= r_it[ST_CHK].last && w_fail;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {7'd0, r_ofail, r_ostat, r_oowned, r_orow, r_ohead[4:0], r_olayer[0]};

    `NGH_ASSERT_IMP(a_issue_blocks_input, r_state == S_ISSUE, !s_axis_tready)
    `NGH_ASSERT_IMP(a_reject_is_last, r_v[ST_CHK] && r_it[ST_CHK].reject, r_it[ST_CHK].last)
    `NGH_ASSERT_NXT(a_stall_holds_pipe, !w_en, $stable(r_v))
    `NGH_ASSERT_IMP(a_fail_only_last, r_ovalid && !r_olast, !r_ofail)

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
    import ngh_pkg::*;

    localparam int HPL = 24;
    localparam int HEADS = 48;
    localparam int MULTS = 8;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 22;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic        layer;
        logic [4:0]  idx;
        logic [63:0] val;
        logic [30:0] off;
        logic        owned;
        logic [31:0] tok;
        logic [1:0]  hlen;
        logic [31:0] h0;
        logic [31:0] h1;
        logic [31:0] h2;
        logic        late;
    } t_hash_req;

    typedef struct packed {
        logic        layer;
        logic [4:0]  head;
        logic [30:0] row;
        logic        owned;
        t_status     status;
        logic        failed;
        logic        last;
    } t_head_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;

    ngram_head_row_hash dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // shadow state
    logic [30:0] pad_code;
    logic [30:0] shard_lo [2];
    logic [30:0] shard_hi [2];
    logic [63:0] mult_tab [MULTS];
    logic [63:0] div_tab [HEADS];
    logic [30:0] off_tab [HEADS];
    logic        own_tab [HEADS];

    t_hash_req pending_q [$];
    t_head_row row_expect_q [$];
    t_hash_req on_bus;
    int gap_left;
    int stall_left;
    int hold_left;
    bit hold_done;
    bit calm;
    int errors;
    int idle_cycles;
    int n_results;
    int n_hashes;
    int n_rejects;
    int n_accepted;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void add_pending(t_hash_req r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    function automatic void add_expect(t_head_row e);
        row_expect_q.insert(row_expect_q.size(), e);
    endfunction

    function automatic logic [63:0] mod_floor(logic [63:0] v, logic [63:0] d);
        logic [63:0] r;
        if (d == 64'd0) return 64'd0;
        if (!v[63]) return v % d;
        r = (~v + 64'd1) % d;
        return (r != 64'd0) ? d - r : 64'd0;
    endfunction

    function automatic void predict_rows(t_hash_req r);
        t_head_row e;
        logic [63:0] roll [2];
        logic [63:0] rem;
        logic [31:0] raw;
        logic [30:0] code;
        logic [30:0] rows [HEADS];
        logic        ovf [HEADS];
        logic        blk;
        logic        failed;
        logic        checked;
        int ix;
        if (r.kind == K_LOAD_HEAD) begin
            if (r.idx < HPL) begin
                if (r.val == 64'd0 || r.val[63]) begin
                    e = '{r.layer, r.idx, 31'd0, 1'b0, STAT_REJ, 1'b1, 1'b1};
                    add_expect(e);
                    n_rejects++;
                end else begin
                    ix = r.layer * HPL + r.idx;
                    div_tab[ix] = r.val;
                    off_tab[ix] = r.off;
                    own_tab[ix] = r.owned;
                end
            end
        end else if (r.kind == K_LOAD_MULT) begin
            if (r.idx <= 5'd3) mult_tab[r.layer * 4 + r.idx] = r.val;
        end else if (r.kind == K_HASH) begin
            n_hashes++;
            blk = 1'b0;
            failed = 1'b0;
            roll[0] = 64'd0;
            roll[1] = 64'd0;
            for (int s = 0; s <= 3; s++) begin
                raw = (s == 0) ? r.tok : (s == 1) ? r.h0 : (s == 2) ? r.h1 : r.h2;
                if (s > r.hlen) begin
                    blk = 1'b1;
                    raw = 32'd0;
                end
                if (raw[31]) blk = 1'b1;
                code = blk ? pad_code : raw[30:0];
                for (int l = 0; l < 2; l++) begin
                    roll[l] ^= {33'd0, code} * mult_tab[l * 4 + s];
                    if (s > 0) begin
                        for (int h = (s - 1) * 8; h < s * 8; h++) begin
                            ix = l * HPL + h;
                            rem = mod_floor(roll[l], div_tab[ix]);
                            if (rem > 64'(ROW_MAX) - 64'(off_tab[ix])) begin
                                rows[ix] = ROW_MAX;
                                ovf[ix] = 1'b1;
                            end else begin
                                rows[ix] = 31'(rem + 64'(off_tab[ix]));
                                ovf[ix] = 1'b0;
                            end
                        end
                    end
                end
            end
            for (int l = 0; l < 2; l++) begin
                checked = !(l == 0 && r.late);
                for (int h = 0; h < HPL; h++) begin
                    ix = l * HPL + h;
                    e = '{l[0], h[4:0], rows[ix], own_tab[ix], STAT_OK, 1'b0, 1'b0};
                    if (ovf[ix]) begin
                        e.status = STAT_OVF;
                    end else if (checked && own_tab[ix]) begin
                        if (!(rows[ix] >= shard_lo[l] && rows[ix] < shard_hi[l]))
                            e.status = STAT_OUT;
                    end
                    if (e.status != STAT_OK) failed = 1'b1;
                    if (ix == HEADS - 1) begin
                        e.failed = failed;
                        e.last = 1'b1;
                    end
                    add_expect(e);
                end
            end
        end
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_req(t_hash_req r);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IN_LAYER] = r.layer;
        d[IN_IDX_LO +: 5] = r.idx;
        d[IN_VAL_LO +: 64] = r.val;
        d[IN_OFF_LO +: 31] = r.off;
        d[IN_OWNED] = r.owned;
        d[IN_TOK_LO +: 32] = r.tok;
        d[IN_HLEN_LO +: 2] = r.hlen;
        d[IN_H0_LO +: 32] = r.h0;
        d[IN_H1_LO +: 32] = r.h1;
        d[IN_H2_LO +: 32] = r.h2;
        d[IN_LATE] = r.late;
        return d;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_rows(on_bus);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    on_bus = pending_q.pop_front();
                    s_axis_tdata <= pack_req(on_bus);
                    s_axis_tuser <= on_bus.kind;
                    s_axis_tvalid <= 1'b1;
                    gap_left <= calm ? 0 : $urandom_range(0, 3);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_head_row e;
        t_head_row got;
        int s;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else begin
            s = stall_left;
            if (m_axis_tvalid && m_axis_tready) begin
                got.layer = m_axis_tdata[0];
                got.head = m_axis_tdata[5:1];
                got.row = m_axis_tdata[36:6];
                got.owned = m_axis_tdata[37];
                got.status = t_status'(m_axis_tdata[39:38]);
                got.failed = m_axis_tdata[40];
                got.last = m_axis_tlast;
                n_results++;
                if (row_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    e = row_expect_q.pop_front();
                    if (got != e) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, e, got);
                    end
                end
                s = calm ? 0 : $urandom_range(0, 3);
            end
            if (!hold_done && n_results >= 200) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (s > 0) begin
                stall_left <= s - 1;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left <= 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, row_expect_q.size());
            $display("** ngram_head_row_hash: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] rand_code();
        case ($urandom_range(0, 4))
            0: return 32'hFFFF_FFFF;
            1: return 32'($urandom_range(0, 15));
            2: return 32'h7FFF_FFFF;
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    function automatic logic [63:0] rand_div();
        logic [63:0] d;
        case ($urandom_range(0, 4))
            0: d = 64'($urandom_range(1, 16));
            1: d = 64'($urandom_range(1, 1 << 20));
            2: d = 64'($urandom_range(1, 32'h7FFF_FFFF));
            3: d = 64'h7FFF_FFFF_FFFF_FFFF;
            default: d = {1'b0, 31'($urandom), 32'($urandom)};
        endcase
        return (d == 64'd0) ? 64'd1 : d;
    endfunction

    function automatic logic [30:0] rand_off();
        case ($urandom_range(0, 3))
            0: return 31'd0;
            1: return ROW_MAX - 31'($urandom_range(0, 1000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic t_hash_req blank_req(logic [1:0] kind);
        t_hash_req r;
        r.kind = kind;
        r.layer = 1'($urandom);
        r.idx = 5'($urandom);
        r.val = {32'($urandom), 32'($urandom)};
        r.off = 31'($urandom);
        r.owned = 1'($urandom);
        r.tok = 32'($urandom);
        r.hlen = 2'($urandom);
        r.h0 = 32'($urandom);
        r.h1 = 32'($urandom);
        r.h2 = 32'($urandom);
        r.late = 1'($urandom);
        return r;
    endfunction

    function automatic t_hash_req head_load(int layer, int head, logic [63:0] d,
                                           logic [30:0] off);
        t_hash_req r;
        r = blank_req(K_LOAD_HEAD);
        r.layer = layer[0];
        r.idx = head[4:0];
        r.val = d;
        r.off = off;
        return r;
    endfunction

    function automatic t_hash_req hash_req(logic [31:0] tok, logic [1:0] hlen,
                                          logic [31:0] h0, logic [31:0] h1,
                                          logic [31:0] h2, logic late);
        t_hash_req r;
        r = blank_req(K_HASH);
        r.tok = tok;
        r.hlen = hlen;
        r.h0 = h0;
        r.h1 = h1;
        r.h2 = h2;
        r.late = late;
        return r;
    endfunction

    function automatic t_hash_req rand_req();
        t_hash_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            r = hash_req(rand_code(), 2'($urandom), rand_code(), rand_code(), rand_code(),
                         1'($urandom));
        end else if (pick < 82) begin
            r = head_load($urandom_range(0, 1), $urandom_range(0, HPL - 1), rand_div(),
                          rand_off());
            if ($urandom_range(0, 9) == 0) r.val = ($urandom_range(0, 1)) ? 64'd0
                                                    : {1'b1, 63'({$urandom, $urandom})};
            if ($urandom_range(0, 12) == 0) r.idx = 5'($urandom_range(HPL, 31));
        end else if (pick < 95) begin
            r = blank_req(K_LOAD_MULT);
            r.idx = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(4, 31))
                                                 : 5'($urandom_range(0, 3));
        end else begin
            r = blank_req(KIND_UNUSED);
        end
        return r;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [30:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_PAD:    pad_code = data;
            CFG_START0: shard_lo[0] = data;
            CFG_STOP0:  shard_hi[0] = data;
            CFG_START1: shard_lo[1] = data;
            CFG_STOP1:  shard_hi[1] = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_axis_tvalid || row_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_shards(logic [30:0] pad, logic [30:0] lo0, logic [30:0] hi0,
                              logic [30:0] lo1, logic [30:0] hi1);
        cfg_write(CFG_PAD, pad);
        cfg_write(CFG_START0, lo0);
        cfg_write(CFG_STOP0, hi0);
        cfg_write(CFG_START1, lo1);
        cfg_write(CFG_STOP1, hi1);
    endtask

    initial begin
        t_hash_req r;
        logic [30:0] a;
        logic [30:0] b;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_PAD;
        i_cfg_data = '0;
        pad_code = '0;
        shard_lo = '{31'd0, 31'd0};
        shard_hi = '{31'd0, 31'd0};
        foreach (own_tab[i]) own_tab[i] = 1'b0;
        foreach (div_tab[i]) div_tab[i] = 64'd0;
        foreach (off_tab[i]) off_tab[i] = 31'd0;
        foreach (mult_tab[i]) mult_tab[i] = 64'd0;
        gap_left = 0;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        calm = 1'b0;
        errors = 0;
        idle_cycles = 0;
        n_results = 0;
        n_hashes = 0;
        n_rejects = 0;
        n_accepted = 0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_shards(31'd0, 31'd0, 31'd1000, 31'd0, ROW_MAX);

        // fill every table entry before any hash
        for (int i = 0; i < MULTS; i++) begin
            r = blank_req(K_LOAD_MULT);
            r.layer = i[2];
            r.idx = 5'(i % 4);
            add_pending(r);
        end
        for (int l = 0; l < 2; l++)
            for (int h = 0; h < HPL; h++)
                add_pending(head_load(l, h, rand_div(), rand_off()));
        add_pending(head_load(0, 0, 64'd1, ROW_MAX));
        add_pending(head_load(1, 23, 64'h7FFF_FFFF_FFFF_FFFF, 31'd0));

        // directed
        add_pending(hash_req(32'h7FFF_FFFF, 2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 1'b0));
        add_pending(hash_req(32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 1'b1));
        add_pending(hash_req(32'd0, 2'd0, 32'd5, 32'd6, 32'd7, 1'b0));
        add_pending(hash_req(32'd9, 2'd1, 32'd5, 32'd6, 32'd7, 1'b1));
        add_pending(hash_req(32'd9, 2'd2, 32'hFFFF_FFFF, 32'd6, 32'd7, 1'b0));
        add_pending(hash_req(32'd9, 2'd3, 32'd5, 32'hFFFF_FFFF, 32'd7, 1'b0));
        add_pending(head_load(0, 3, 64'd0, 31'd0));
        add_pending(head_load(1, 7, 64'h8000_0000_0000_0000, ROW_MAX));
        add_pending(head_load(1, 31, 64'd0, 31'd0));
        r = blank_req(K_LOAD_MULT);
        r.idx = 5'd31;
        add_pending(r);
        add_pending(blank_req(KIND_UNUSED));
        add_pending(head_load(0, 5, 64'd3, 31'd0));
        add_pending(hash_req(32'd1, 2'd3, 32'd2, 32'd3, 32'd4, 1'b0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_shards(ROW_MAX, ROW_MAX, ROW_MAX, 31'd0, 31'd0);
                1: set_shards(31'($urandom), 31'd0, ROW_MAX, 31'd500, 31'd100);
                default: begin
                    a = 31'($urandom);
                    b = 31'($urandom);
                    set_shards(31'($urandom_range(0, 100)), (a < b) ? a : b,
                               (a < b) ? b : a, 31'd0, 31'($urandom));
                end
            endcase
            calm = (ph == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) add_pending(rand_req());
            drain();
        end

        $display("Accepted %0d items: %0d hash requests, %0d rejected loads, %0d results.",
                 n_accepted, n_hashes, n_rejects, n_results);
        $display("Covered five register settings, table reloads and a long output hold-off.");
        if (errors == 0) begin
            $display("** ngram_head_row_hash: PASSED **");
        end else begin
            $display("** ngram_head_row_hash: FAILED **");
        end
        $finish;
    end
endmodule
